// File: rtl/rqg_pkg.sv
// Shared types, codes and widths of the resource quota guard.
package rqg_pkg;

  localparam int COUNTER_WIDTH_DEF = 48;
  localparam int AMOUNT_WIDTH_DEF  = 32;

  localparam int LIMIT_W    = 48;
  localparam int ALLOC_W    = 32;
  localparam int SMALL_W    = 16;
  localparam int OP_W       = 4;
  localparam int ERR_W      = 3;
  localparam int STATE_W    = 3;
  localparam int FLAG_W     = 6;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_IDX_LO = 3;

  // Bit positions in limit_flags.
  localparam int FLAG_MEMORY  = 0;
  localparam int FLAG_CPU     = 1;
  localparam int FLAG_INSTR   = 2;
  localparam int FLAG_HANDLES = 3;
  localparam int FLAG_THREADS = 4;
  localparam int FLAG_ALLOCS  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC      = 4'd0,
    OP_FREE       = 4'd1,
    OP_CPU        = 4'd2,
    OP_INSTR      = 4'd3,
    OP_OPEN       = 4'd4,
    OP_CLOSE      = 4'd5,
    OP_THREAD_NEW = 4'd6,
    OP_THREAD_END = 4'd7,
    OP_ENTER      = 4'd8,
    OP_EXIT       = 4'd9,
    OP_SUSPEND    = 4'd10,
    OP_RESUME     = 4'd11,
    OP_TERMINATE  = 4'd12,
    OP_CLEAR      = 4'd13
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE          = 3'd0,
    ERR_MEMORY        = 3'd1,
    ERR_CPU           = 3'd2,
    ERR_INSTR         = 3'd3,
    ERR_HANDLES       = 3'd4,
    ERR_THREAD_DENIED = 3'd5,
    ERR_THREAD_LIMIT  = 3'd6,
    ERR_ENTER         = 3'd7
  } err_t;

  typedef enum logic [STATE_W-1:0] {
    ST_CREATED    = 3'd0,
    ST_RUNNING    = 3'd1,
    ST_SUSPENDED  = 3'd2,
    ST_TERMINATED = 3'd3,
    ST_VIOLATED   = 3'd4
  } run_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEMORY_LIMIT      = 3'd0,
    REG_ALLOCATION_LIMIT  = 3'd1,
    REG_CPU_TIME_LIMIT    = 3'd2,
    REG_INSTRUCTION_LIMIT = 3'd3,
    REG_HANDLE_LIMIT      = 3'd4,
    REG_THREAD_LIMIT      = 3'd5,
    REG_VIOLATION_LIMIT   = 3'd6,
    REG_THREAD_PERMITTED  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] memory_limit;
    logic [ALLOC_W-1:0] allocation_limit;
    logic [LIMIT_W-1:0] cpu_time_limit;
    logic [LIMIT_W-1:0] instruction_limit;
    logic [SMALL_W-1:0] handle_limit;
    logic [SMALL_W-1:0] thread_limit;
    logic [SMALL_W-1:0] violation_limit;
    logic               thread_permitted;
  } limits_t;

  typedef struct packed {
    logic               ok;
    err_t               error_code;
    run_state_t         run_state;
    logic [SMALL_W-1:0] violations;
    logic [FLAG_W-1:0]  limit_flags;
  } status_t;

endpackage

// File: rtl/rqg_cfg.sv
// Configuration register file with its APB-style access port.
module rqg_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rqg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rqg_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rqg_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output rqg_pkg::limits_t               limits
);
  import rqg_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_IDX_LO +: CFG_IDX_W]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_MEMORY_LIMIT:      limits.memory_limit      <= pwdata[LIMIT_W-1:0];
        REG_ALLOCATION_LIMIT:  limits.allocation_limit  <= pwdata[ALLOC_W-1:0];
        REG_CPU_TIME_LIMIT:    limits.cpu_time_limit    <= pwdata[LIMIT_W-1:0];
        REG_INSTRUCTION_LIMIT: limits.instruction_limit <= pwdata[LIMIT_W-1:0];
        REG_HANDLE_LIMIT:      limits.handle_limit      <= pwdata[SMALL_W-1:0];
        REG_THREAD_LIMIT:      limits.thread_limit      <= pwdata[SMALL_W-1:0];
        REG_VIOLATION_LIMIT:   limits.violation_limit   <= pwdata[SMALL_W-1:0];
        REG_THREAD_PERMITTED:  limits.thread_permitted  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MEMORY_LIMIT:      prdata = CFG_DATA_W'(limits.memory_limit);
      REG_ALLOCATION_LIMIT:  prdata = CFG_DATA_W'(limits.allocation_limit);
      REG_CPU_TIME_LIMIT:    prdata = CFG_DATA_W'(limits.cpu_time_limit);
      REG_INSTRUCTION_LIMIT: prdata = CFG_DATA_W'(limits.instruction_limit);
      REG_HANDLE_LIMIT:      prdata = CFG_DATA_W'(limits.handle_limit);
      REG_THREAD_LIMIT:      prdata = CFG_DATA_W'(limits.thread_limit);
      REG_VIOLATION_LIMIT:   prdata = CFG_DATA_W'(limits.violation_limit);
      REG_THREAD_PERMITTED:  prdata = CFG_DATA_W'(limits.thread_permitted);
      default:               prdata = '0;
    endcase
  end

endmodule

// File: rtl/rqg_usage.sv
// Usage counters, run state and the single-pass decision for one request.
module rqg_usage #(
  parameter int COUNTER_WIDTH = rqg_pkg::COUNTER_WIDTH_DEF,
  parameter int AMOUNT_WIDTH  = rqg_pkg::AMOUNT_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  rqg_pkg::op_t             op,
  input  logic [AMOUNT_WIDTH-1:0]  amount,
  input  rqg_pkg::limits_t         limits,
  output rqg_pkg::status_t         status,
  output logic [COUNTER_WIDTH-1:0] memory_now,
  output logic [COUNTER_WIDTH-1:0] memory_high
);
  import rqg_pkg::*;

  // Sums carry one bit beyond the wider operand, and compares also cover the limits.
  localparam int WIDE_W = ((COUNTER_WIDTH > AMOUNT_WIDTH) ? COUNTER_WIDTH : AMOUNT_WIDTH) + 1;
  localparam int CMP_W  = (WIDE_W > LIMIT_W) ? WIDE_W : LIMIT_W;

  localparam logic [CMP_W-1:0]         CNT_MAX   = CMP_W'({COUNTER_WIDTH{1'b1}});
  localparam logic [ALLOC_W-1:0]       ALLOC_MAX = '1;
  localparam logic [SMALL_W-1:0]       SMALL_MAX = '1;

  logic [COUNTER_WIDTH-1:0] memory_used, memory_used_next;
  logic [COUNTER_WIDTH-1:0] memory_peak, memory_peak_next;
  logic [COUNTER_WIDTH-1:0] cpu_time_used, cpu_time_used_next;
  logic [COUNTER_WIDTH-1:0] instructions_run, instructions_run_next;
  logic [ALLOC_W-1:0]       allocation_count, allocation_count_next;
  logic [SMALL_W-1:0]       open_handles, open_handles_next;
  logic [SMALL_W-1:0]       active_threads, active_threads_next;
  logic [SMALL_W-1:0]       violation_count, violation_count_next;
  run_state_t               context_state, context_state_next;

  logic [CMP_W-1:0] mem_sum, cpu_sum, instr_sum, amount_wide;
  logic             mem_over, cpu_over, instr_over, alloc_full;
  logic             ok;
  err_t             err;
  logic [FLAG_W-1:0] flags;

  function automatic logic [COUNTER_WIDTH-1:0] sat_cnt(input logic [CMP_W-1:0] s);
    return (s > CNT_MAX) ? {COUNTER_WIDTH{1'b1}} : s[COUNTER_WIDTH-1:0];
  endfunction

  // A zero limit means unlimited; otherwise the exact sum must not pass it.
  function automatic logic exceeds(input logic [CMP_W-1:0] s, input logic [LIMIT_W-1:0] lim);
    return (lim != '0) && (s > CMP_W'(lim));
  endfunction

  assign amount_wide = CMP_W'(amount);
  assign mem_sum     = CMP_W'(memory_used) + amount_wide;
  assign cpu_sum     = CMP_W'(cpu_time_used) + amount_wide;
  assign instr_sum   = CMP_W'(instructions_run) + amount_wide;
  assign mem_over    = exceeds(mem_sum, limits.memory_limit);
  assign cpu_over    = exceeds(cpu_sum, limits.cpu_time_limit);
  assign instr_over  = exceeds(instr_sum, limits.instruction_limit);
  assign alloc_full  = (limits.allocation_limit != '0) &&
                       (allocation_count >= limits.allocation_limit);

  always_comb begin
    memory_used_next      = memory_used;
    memory_peak_next      = memory_peak;
    cpu_time_used_next    = cpu_time_used;
    instructions_run_next = instructions_run;
    allocation_count_next = allocation_count;
    open_handles_next     = open_handles;
    active_threads_next   = active_threads;
    violation_count_next  = violation_count;
    context_state_next    = context_state;
    ok  = 1'b1;
    err = ERR_NONE;

    case (op)
      OP_ALLOC: begin
        if (mem_over || alloc_full) begin
          ok  = 1'b0;
          err = ERR_MEMORY;
        end else begin
          memory_used_next      = sat_cnt(mem_sum);
          allocation_count_next = (allocation_count == ALLOC_MAX) ? ALLOC_MAX
                                                                  : allocation_count + 1'b1;
          if (memory_used_next > memory_peak) begin
            memory_peak_next = memory_used_next;
          end
        end
      end
      OP_FREE: begin
        memory_used_next = (amount_wide >= CMP_W'(memory_used)) ? '0
                         : memory_used - COUNTER_WIDTH'(amount_wide);
      end
      OP_CPU: begin
        if (cpu_over) begin
          ok  = 1'b0;
          err = ERR_CPU;
        end else begin
          cpu_time_used_next = sat_cnt(cpu_sum);
        end
      end
      OP_INSTR: begin
        if (instr_over) begin
          ok  = 1'b0;
          err = ERR_INSTR;
        end else begin
          instructions_run_next = sat_cnt(instr_sum);
        end
      end
      OP_OPEN: begin
        if ((limits.handle_limit != '0) && (open_handles >= limits.handle_limit)) begin
          ok  = 1'b0;
          err = ERR_HANDLES;
        end else if (open_handles != SMALL_MAX) begin
          open_handles_next = open_handles + 1'b1;
        end
      end
      OP_CLOSE: begin
        if (open_handles != '0) begin
          open_handles_next = open_handles - 1'b1;
        end
      end
      OP_THREAD_NEW: begin
        if (!limits.thread_permitted) begin
          ok  = 1'b0;
          err = ERR_THREAD_DENIED;
        end else if ((limits.thread_limit != '0) &&
                     (active_threads >= limits.thread_limit)) begin
          ok  = 1'b0;
          err = ERR_THREAD_LIMIT;
        end else if (active_threads != SMALL_MAX) begin
          active_threads_next = active_threads + 1'b1;
        end
      end
      OP_THREAD_END: begin
        if (active_threads != '0) begin
          active_threads_next = active_threads - 1'b1;
        end
      end
      OP_ENTER: begin
        if (context_state == ST_TERMINATED || context_state == ST_VIOLATED) begin
          ok  = 1'b0;
          err = ERR_ENTER;
        end else begin
          context_state_next = ST_RUNNING;
        end
      end
      OP_EXIT: begin
        if (context_state == ST_RUNNING) begin
          context_state_next = ST_CREATED;
        end
      end
      OP_SUSPEND: begin
        if (context_state == ST_RUNNING) begin
          context_state_next = ST_SUSPENDED;
        end
      end
      OP_RESUME: begin
        if (context_state == ST_SUSPENDED) begin
          context_state_next = ST_RUNNING;
        end
      end
      OP_TERMINATE: begin
        context_state_next = ST_TERMINATED;
      end
      OP_CLEAR: begin
        memory_used_next      = '0;
        memory_peak_next      = '0;
        cpu_time_used_next    = '0;
        instructions_run_next = '0;
        allocation_count_next = '0;
        open_handles_next     = '0;
        active_threads_next   = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase

    // Every refused usage request is a violation; a refused enter is not.
    if (err != ERR_NONE && err != ERR_ENTER) begin
      if (violation_count != SMALL_MAX) begin
        violation_count_next = violation_count + 1'b1;
      end
      if ((limits.violation_limit != '0) &&
          (violation_count_next >= limits.violation_limit)) begin
        context_state_next = ST_VIOLATED;
      end
    end
  end

  always_comb begin
    flags = '0;
    flags[FLAG_MEMORY]  = exceeds(CMP_W'(memory_used_next), limits.memory_limit);
    flags[FLAG_CPU]     = exceeds(CMP_W'(cpu_time_used_next), limits.cpu_time_limit);
    flags[FLAG_INSTR]   = exceeds(CMP_W'(instructions_run_next), limits.instruction_limit);
    flags[FLAG_HANDLES] = (limits.handle_limit != '0) &&
                          (open_handles_next > limits.handle_limit);
    flags[FLAG_THREADS] = (limits.thread_limit != '0) &&
                          (active_threads_next > limits.thread_limit);
    flags[FLAG_ALLOCS]  = (limits.allocation_limit != '0) &&
                          (allocation_count_next > limits.allocation_limit);
  end

  assign status.ok          = ok;
  assign status.error_code  = err;
  assign status.run_state   = context_state_next;
  assign status.violations  = violation_count_next;
  assign status.limit_flags = flags;
  assign memory_now         = memory_used_next;
  assign memory_high        = memory_peak_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_used      <= '0;
      memory_peak      <= '0;
      cpu_time_used    <= '0;
      instructions_run <= '0;
      allocation_count <= '0;
      open_handles     <= '0;
      active_threads   <= '0;
      violation_count  <= '0;
      context_state    <= ST_CREATED;
    end else if (step) begin
      memory_used      <= memory_used_next;
      memory_peak      <= memory_peak_next;
      cpu_time_used    <= cpu_time_used_next;
      instructions_run <= instructions_run_next;
      allocation_count <= allocation_count_next;
      open_handles     <= open_handles_next;
      active_threads   <= active_threads_next;
      violation_count  <= violation_count_next;
      context_state    <= context_state_next;
    end
  end

endmodule

// File: rtl/resource_quota_guard.sv
// Top level of the resource quota guard: request and result registers around the usage logic.
//
//   Channel   Handshake               Word
//   config    psel/penable/pready     paddr, pwdata, prdata (64 bits, registers at 8*i)
//   request   req_valid / req_stall   op, amount
//   result    rsp_valid / rsp_stall   ok, error_code, run_state, violations,
//                                     limit_flags, memory_now, memory_high
//
// A request word is captured in the request register, then decided and applied to the
// counters, and its result word is registered at the same edge that updates the counters;
// the rate is one word per cycle while the result channel does not stall.
// The counter update is one wide add and compare per counter, all combinational.
// Reset clears every counter, the violation count and the limits and puts the
// context in the created state; there is no clearing pass.
// A stalled result holds the decision stage; the request register keeps its word
// and req_stall rises, so a word already taken is never lost or applied twice.
module resource_quota_guard #(
  parameter int COUNTER_WIDTH = rqg_pkg::COUNTER_WIDTH_DEF,
  parameter int AMOUNT_WIDTH  = rqg_pkg::AMOUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rqg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rqg_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rqg_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  // Request channel.
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [rqg_pkg::OP_W-1:0]       op,
  input  logic [AMOUNT_WIDTH-1:0]        amount,
  // Result channel.
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic                           ok,
  output logic [rqg_pkg::ERR_W-1:0]      error_code,
  output logic [rqg_pkg::STATE_W-1:0]    run_state,
  output logic [rqg_pkg::SMALL_W-1:0]    violations,
  output logic [rqg_pkg::FLAG_W-1:0]     limit_flags,
  output logic [COUNTER_WIDTH-1:0]       memory_now,
  output logic [COUNTER_WIDTH-1:0]       memory_high
);
  import rqg_pkg::*;

  limits_t limits;

  // Request register.
  logic                    req_full;
  logic [OP_W-1:0]         op_q;
  logic [AMOUNT_WIDTH-1:0] amount_q;

  // Decision outputs, captured into the result register.
  status_t                  status;
  logic [COUNTER_WIDTH-1:0] mem_now_d;
  logic [COUNTER_WIDTH-1:0] mem_high_d;

  logic step;

  // The held word is decided when the result register is empty or being drained.
  assign step      = req_full && (!rsp_valid || !rsp_stall);
  assign req_stall = req_full && !step;

  rqg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  rqg_usage #(
    .COUNTER_WIDTH (COUNTER_WIDTH),
    .AMOUNT_WIDTH  (AMOUNT_WIDTH)
  ) u_usage (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .op          (op_t'(op_q)),
    .amount      (amount_q),
    .limits      (limits),
    .status      (status),
    .memory_now  (mem_now_d),
    .memory_high (mem_high_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (!req_stall) begin
      req_full <= req_valid;
    end
    if (req_valid && !req_stall) begin
      op_q     <= op;
      amount_q <= amount;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (step) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (step) begin
      ok          <= status.ok;
      error_code  <= status.error_code;
      run_state   <= status.run_state;
      violations  <= status.violations;
      limit_flags <= status.limit_flags;
      memory_now  <= mem_now_d;
      memory_high <= mem_high_d;
    end
  end

endmodule
